// ===== rtl/u16rm_pkg.sv =====
// ----------------------------------------------------------------------------
// u16rm_pkg
// Shared types and constants of the 16550-style UART register model.
// ----------------------------------------------------------------------------
package u16rm_pkg;

  // Size of the decoded address window in bytes (32 .. 256).
  localparam int unsigned WindowBytes = 256;

  // Register indexes of the 16550 map; index 6 does not exist.
  localparam logic [2:0] RegRbr = 3'd0;  // RBR / THR / DLL
  localparam logic [2:0] RegIer = 3'd1;  // IER / DLM
  localparam logic [2:0] RegIir = 3'd2;  // IIR / FCR
  localparam logic [2:0] RegLcr = 3'd3;
  localparam logic [2:0] RegMcr = 3'd4;
  localparam logic [2:0] RegLsr = 3'd5;
  localparam logic [2:0] RegGap = 3'd6;
  localparam logic [2:0] RegScr = 3'd7;

  // Offsets of the word-stride layout.
  localparam logic [7:0] OffWordRbr = 8'h00;
  localparam logic [7:0] OffWordIer = 8'h04;
  localparam logic [7:0] OffWordIir = 8'h08;
  localparam logic [7:0] OffWordLcr = 8'h0C;
  localparam logic [7:0] OffWordMcr = 8'h10;
  localparam logic [7:0] OffWordLsr = 8'h14;
  localparam logic [7:0] OffWordScr = 8'h1C;

  localparam int unsigned LcrDlabBit = 7;
  localparam logic [7:0]  IirValue   = 8'h01;
  localparam logic [7:0]  LsrBase    = 8'h60;

  localparam logic AccRead  = 1'b0;
  localparam logic AccWrite = 1'b1;

  typedef enum logic [1:0] {
    StrideNone = 2'd0,
    StrideByte = 2'd1,
    StrideWord = 2'd2
  } stride_e;

  typedef struct packed {
    logic        action;
    logic [7:0]  offset;
    logic [31:0] write_data;
    logic        rx_avail;
    logic [7:0]  rx_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       irq_level;
    logic       rx_taken;
  } rsp_t;

endpackage

// ===== rtl/u16rm_if.sv =====
// ----------------------------------------------------------------------------
// u16rm_req_if / u16rm_rsp_if
// Valid/ready channels carrying bus accesses and their results.
// ----------------------------------------------------------------------------
interface u16rm_req_if;
  import u16rm_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface u16rm_rsp_if;
  import u16rm_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/u16rm_core.sv =====
// ----------------------------------------------------------------------------
// u16rm_core
// Architectural register state, offset decode and access side effects.
// ----------------------------------------------------------------------------
module u16rm_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  u16rm_pkg::req_t req_i,
  output u16rm_pkg::rsp_t rsp_o
);
  import u16rm_pkg::*;

  stride_e     stride_q, stride_d, stride_eff;
  logic [7:0]  lcr_q, lcr_d;
  logic [3:0]  ier_q, ier_d;
  logic [7:0]  dll_q, dll_d;
  logic [7:0]  dlm_q, dlm_d;
  logic [4:0]  mcr_q, mcr_d;
  logic [7:0]  scr_q, scr_d;
  logic        rx_ready_q, rx_ready_d;
  logic [7:0]  rx_hold_q, rx_hold_d;

  logic       in_win;
  logic       word_only;
  logic [2:0] reg_sel;
  logic       reg_ok;
  logic       dlab;
  logic       offer;

  // Stride and register select
  always_comb begin
    in_win    = ({1'b0, req_i.offset} < 9'(WindowBytes));
    word_only = (req_i.offset == OffWordIir) || (req_i.offset == OffWordLcr) ||
                (req_i.offset == OffWordMcr) || (req_i.offset == OffWordLsr) ||
                (req_i.offset == OffWordScr);
    unique case (stride_q)
      StrideByte: stride_eff = StrideByte;
      StrideWord: stride_eff = StrideWord;
      default:    stride_eff = word_only ? StrideWord : StrideByte;
    endcase

    reg_sel = req_i.offset[2:0];
    reg_ok  = 1'b1;
    if (stride_eff == StrideWord) begin
      unique case (req_i.offset)
        OffWordRbr: reg_sel = RegRbr;
        OffWordIer: reg_sel = RegIer;
        OffWordIir: reg_sel = RegIir;
        OffWordLcr: reg_sel = RegLcr;
        OffWordMcr: reg_sel = RegMcr;
        OffWordLsr: reg_sel = RegLsr;
        OffWordScr: reg_sel = RegScr;
        default: begin
          reg_sel = RegGap;
          reg_ok  = 1'b0;
        end
      endcase
    end else begin
      reg_ok = (reg_sel != RegGap);
    end
  end

  // Access effects
  always_comb begin
    stride_d   = stride_q;
    lcr_d      = lcr_q;
    ier_d      = ier_q;
    dll_d      = dll_q;
    dlm_d      = dlm_q;
    mcr_d      = mcr_q;
    scr_d      = scr_q;
    rx_ready_d = rx_ready_q;
    rx_hold_d  = rx_hold_q;
    rsp_o      = '0;
    dlab       = lcr_q[LcrDlabBit];
    offer      = !rx_ready_q && req_i.rx_avail;

    if (in_win) begin
      stride_d = stride_eff;
      if (reg_ok) begin
        if (req_i.action == AccRead) begin
          unique case (reg_sel)
            RegRbr: begin
              if (dlab) begin
                rsp_o.read_data = dll_q;
              end else if (offer) begin
                // latched and consumed by the same read
                rsp_o.rx_taken  = 1'b1;
                rsp_o.read_data = req_i.rx_data;
                rx_hold_d       = req_i.rx_data;
              end else if (rx_ready_q) begin
                rsp_o.read_data = rx_hold_q;
                rx_ready_d      = 1'b0;
              end
            end
            RegIer: rsp_o.read_data = dlab ? dlm_q : {4'b0, ier_q};
            RegIir: rsp_o.read_data = IirValue;
            RegLcr: rsp_o.read_data = lcr_q;
            RegMcr: rsp_o.read_data = {3'b0, mcr_q};
            RegLsr: begin
              if (offer) begin
                rsp_o.rx_taken = 1'b1;
                rx_ready_d     = 1'b1;
                rx_hold_d      = req_i.rx_data;
              end
              rsp_o.read_data = LsrBase | {7'b0, rx_ready_q | offer};
            end
            RegScr: rsp_o.read_data = scr_q;
            default: rsp_o.read_data = '0;
          endcase
        end else begin
          unique case (reg_sel)
            RegRbr: begin
              if (dlab) begin
                dll_d = req_i.write_data[7:0];
              end else begin
                rsp_o.tx_valid = 1'b1;
                rsp_o.tx_data  = req_i.write_data[7:0];
              end
            end
            RegIer: begin
              if (dlab) dlm_d = req_i.write_data[7:0];
              else      ier_d = req_i.write_data[3:0];
            end
            RegLcr: lcr_d = req_i.write_data[7:0];
            RegMcr: mcr_d = req_i.write_data[4:0];
            RegScr: scr_d = req_i.write_data[7:0];
            default: ;
          endcase
        end
      end
    end

    rsp_o.irq_level = rx_ready_d & ier_d[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q   <= StrideNone;
      lcr_q      <= '0;
      ier_q      <= '0;
      dll_q      <= '0;
      dlm_q      <= '0;
      mcr_q      <= '0;
      scr_q      <= '0;
      rx_ready_q <= 1'b0;
      rx_hold_q  <= '0;
    end else if (fire_i) begin
      stride_q   <= stride_d;
      lcr_q      <= lcr_d;
      ier_q      <= ier_d;
      dll_q      <= dll_d;
      dlm_q      <= dlm_d;
      mcr_q      <= mcr_d;
      scr_q      <= scr_d;
      rx_ready_q <= rx_ready_d;
      rx_hold_q  <= rx_hold_d;
    end
  end

endmodule

// ===== rtl/uart_16550_register_model_unit.sv =====
// ----------------------------------------------------------------------------
// uart_16550_register_model_unit
// Register model of a 16550-style UART behind valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one bus access per beat (read/write, offset, write data and
//   the receive byte currently offered by the line side). rsp_o returns one
//   beat per access: read data, transmit byte, interrupt level and whether
//   the offered receive byte was taken.
//   A request beat passes through the request register and then the response
//   register. Throughput is one access per cycle while rsp_o is not stalled,
//   set by the single decode/update pass between them.
//   When rsp_o is stalled the response register holds; the request register
//   still accepts one more access, after which req_i.ready drops until the
//   response side drains.
//   Reset clears all UART registers, the held receive byte and the stride
//   lock; both pipeline registers come up empty.
// ----------------------------------------------------------------------------
module uart_16550_register_model_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  u16rm_req_if.sink          req_i,
  u16rm_rsp_if.source        rsp_o
);
  import u16rm_pkg::*;

  logic s1_valid_q;
  req_t s1_q;
  logic out_valid_q;
  rsp_t out_q;
  rsp_t core_rsp;
  logic fire;

  assign fire        = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || fire;

  u16rm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (s1_q),
    .rsp_o  (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) s1_valid_q <= req_i.valid;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) s1_q <= req_i.payload;
    if (fire) out_q <= core_rsp;
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

endmodule

// ===== rtl/u16rm_checker.sv =====
// ----------------------------------------------------------------------------
// u16rm_checker
// Port-level checks of the UART register model, bound to the top level.
// ----------------------------------------------------------------------------
module u16rm_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_i,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input u16rm_pkg::rsp_t rsp_payload_i
);
  import u16rm_pkg::*;

  // stalled response beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("response changed while stalled");

  // no transmit, no transmit data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_payload_i.tx_valid |-> rsp_payload_i.tx_data == 8'h00)
    else $error("tx_data set without tx_valid");

  // a transmit beat never returns read data or takes a receive byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_payload_i.tx_valid |->
      rsp_payload_i.read_data == 8'h00 && !rsp_payload_i.rx_taken)
    else $error("transmit beat with read side effects");

  // request side never blocks while the whole pipe is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i && $past(!req_valid_i) && $past(!rsp_valid_i) |-> req_ready_i)
    else $error("request stalled with empty pipeline");

endmodule

bind uart_16550_register_model_unit u16rm_checker u_u16rm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the 16550-style UART register model. A directed table
// exercises reset values, register masks, the divisor latch, the receive
// holding register, transmit writes and invalid offsets. Random UART driver
// sequences and noise accesses follow. Every response beat is compared with
// a behavioral model kept inside the bench, under random back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import u16rm_pkg::*;

  localparam int TargetBeats    = 1400;
  localparam int HoldOffCycles  = 64;
  localparam int WatchdogLimit  = 2000;
  localparam int TailCycles     = 8;
  localparam int MaxReportLines = 100;

  typedef struct packed {
    logic        act;
    logic [2:0]  sel;
    logic        raw;     // use off as is instead of the register's offset
    logic [7:0]  off;
    logic [31:0] wd;
    logic        av;
    logic [7:0]  rxd;
    logic        typed;   // rd below is the known read value
    logic [7:0]  rd;
  } dir_row_t;

  localparam dir_row_t DirTable [26] = '{
    '{AccRead,  RegIir, 1'b0, 8'h00, 32'h0000_0000, 1'b0, 8'h00, 1'b1, IirValue},
    '{AccRead,  RegLcr, 1'b0, 8'h00, 32'h0000_0000, 1'b0, 8'h00, 1'b1, 8'h00},
    '{AccRead,  RegLsr, 1'b0, 8'h00, 32'h0000_0000, 1'b0, 8'h00, 1'b1, LsrBase},
    '{AccRead,  RegRbr, 1'b0, 8'h00, 32'h0000_0000, 1'b0, 8'h00, 1'b1, 8'h00},
    '{AccWrite, RegScr, 1'b0, 8'h00, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0, 8'h00},
    '{AccRead,  RegScr, 1'b0, 8'h00, 32'h0000_0000, 1'b0, 8'h00, 1'b1, 8'hFF},
    '{AccWrite, RegMcr, 1'b0, 8'h00, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0, 8'h00},
    '{AccRead,  RegMcr, 1'b0, 8'h00, 32'h0000_0000, 1'b0, 8'h00, 1'b1, 8'h1F},
    '{AccWrite, RegIer, 1'b0, 8'h00, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0, 8'h00},
    '{AccRead,  RegIer, 1'b0, 8'h00, 32'h0000_0000, 1'b0, 8'h00, 1'b1, 8'h0F},
    '{AccWrite, RegLcr, 1'b0, 8'h00, 32'hFFFF_FF80, 1'b0, 8'h00, 1'b0, 8'h00},
    '{AccWrite, RegRbr, 1'b0, 8'h00, 32'h1234_56FF, 1'b0, 8'h00, 1'b0, 8'h00},
    '{AccWrite, RegIer, 1'b0, 8'h00, 32'h0000_00A5, 1'b0, 8'h00, 1'b0, 8'h00},
    '{AccRead,  RegRbr, 1'b0, 8'h00, 32'h0000_0000, 1'b1, 8'h3C, 1'b1, 8'hFF},
    '{AccRead,  RegIer, 1'b0, 8'h00, 32'h0000_0000, 1'b0, 8'h00, 1'b1, 8'hA5},
    '{AccWrite, RegLcr, 1'b0, 8'h00, 32'h0000_0003, 1'b0, 8'h00, 1'b0, 8'h00},
    '{AccRead,  RegLsr, 1'b0, 8'h00, 32'h0000_0000, 1'b1, 8'hFF, 1'b1, LsrBase | 8'h01},
    '{AccRead,  RegLsr, 1'b0, 8'h00, 32'h0000_0000, 1'b1, 8'h00, 1'b1, LsrBase | 8'h01},
    '{AccRead,  RegRbr, 1'b0, 8'h00, 32'h0000_0000, 1'b1, 8'h00, 1'b1, 8'hFF},
    '{AccRead,  RegRbr, 1'b0, 8'h00, 32'h0000_0000, 1'b1, 8'h00, 1'b1, 8'h00},
    '{AccWrite, RegRbr, 1'b0, 8'h00, 32'hFFFF_FF00, 1'b0, 8'h00, 1'b0, 8'h00},
    '{AccWrite, RegRbr, 1'b0, 8'h00, 32'h0000_00FF, 1'b0, 8'h00, 1'b0, 8'h00},
    '{AccWrite, RegIir, 1'b0, 8'h00, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0, 8'h00},
    '{AccWrite, RegGap, 1'b0, 8'h00, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0, 8'h00},
    '{AccRead,  RegGap, 1'b0, 8'h00, 32'h0000_0000, 1'b0, 8'h00, 1'b1, 8'h00},
    '{AccRead,  RegGap, 1'b1, 8'hFF, 32'h0000_0000, 1'b0, 8'h00, 1'b0, 8'h00}
  };

  logic clk_i;
  logic rst_ni;

  u16rm_req_if req_if ();
  u16rm_rsp_if rsp_if ();

  uart_16550_register_model_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Model state of the UART registers
  stride_e    stride_q   = StrideNone;
  logic [7:0] lcr_q      = '0;
  logic [3:0] ier_q      = '0;
  logic [7:0] dll_q      = '0;
  logic [7:0] dlm_q      = '0;
  logic [4:0] mcr_q      = '0;
  logic [7:0] scr_q      = '0;
  logic       rx_full_q  = 1'b0;
  logic [7:0] rbr_hold_q = '0;

  rsp_t access_results_q [$];

  bit word_stride;
  bit hold_off_req = 1'b0;
  int beats_sent   = 0;
  int results_seen = 0;
  int tx_bytes     = 0;
  int rx_latched   = 0;
  int hold_offs    = 0;
  int drains       = 0;
  int mismatches   = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;
  rsp_t want;
  rsp_t got;

  // ------------------------------------------------------------------
  // Behavioral model
  // ------------------------------------------------------------------
  function automatic logic take_offer(logic avail, logic [7:0] data);
    if (!rx_full_q && avail) begin
      rx_full_q  = 1'b1;
      rbr_hold_q = data;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic rsp_t uart_regs_predict(req_t acc);
    rsp_t res;
    logic [2:0] sel;
    logic sel_ok;
    logic dlab;
    res = '0;
    sel = RegGap;
    sel_ok = 1'b0;
    if (acc.offset < WindowBytes) begin
      // first access in the window locks the stride
      if (stride_q == StrideNone) begin
        stride_q = (acc.offset == OffWordIir || acc.offset == OffWordLcr ||
                    acc.offset == OffWordMcr || acc.offset == OffWordLsr ||
                    acc.offset == OffWordScr) ? StrideWord : StrideByte;
      end
      if (stride_q == StrideWord) begin
        sel_ok = 1'b1;
        case (acc.offset)
          OffWordRbr: sel = RegRbr;
          OffWordIer: sel = RegIer;
          OffWordIir: sel = RegIir;
          OffWordLcr: sel = RegLcr;
          OffWordMcr: sel = RegMcr;
          OffWordLsr: sel = RegLsr;
          OffWordScr: sel = RegScr;
          default:    sel_ok = 1'b0;
        endcase
      end else begin
        sel = acc.offset[2:0];
        sel_ok = (sel != RegGap);
      end
    end
    dlab = lcr_q[LcrDlabBit];
    if (sel_ok && acc.action == AccRead) begin
      case (sel)
        RegRbr: begin
          if (dlab) begin
            res.read_data = dll_q;
          end else begin
            res.rx_taken = take_offer(acc.rx_avail, acc.rx_data);
            if (rx_full_q) begin
              res.read_data = rbr_hold_q;
              rx_full_q = 1'b0;
            end
          end
        end
        RegIer: res.read_data = dlab ? dlm_q : {4'b0000, ier_q};
        RegIir: res.read_data = IirValue;
        RegLcr: res.read_data = lcr_q;
        RegMcr: res.read_data = {3'b000, mcr_q};
        RegLsr: begin
          res.rx_taken = take_offer(acc.rx_avail, acc.rx_data);
          res.read_data = LsrBase | {7'b0, rx_full_q};
        end
        RegScr: res.read_data = scr_q;
        default: res.read_data = '0;
      endcase
    end else if (sel_ok) begin
      case (sel)
        RegRbr: begin
          if (dlab) begin
            dll_q = acc.write_data[7:0];
          end else begin
            res.tx_valid = 1'b1;
            res.tx_data  = acc.write_data[7:0];
          end
        end
        RegIer: begin
          if (dlab) begin
            dlm_q = acc.write_data[7:0];
          end else begin
            ier_q = acc.write_data[3:0];
          end
        end
        RegLcr: lcr_q = acc.write_data[7:0];
        RegMcr: mcr_q = acc.write_data[4:0];
        RegScr: scr_q = acc.write_data[7:0];
        default: ;
      endcase
    end
    res.irq_level = rx_full_q & ier_q[0];
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic logic [7:0] reg_offset(logic [2:0] sel);
    logic [4:0] upper_bits;
    upper_bits = 5'($urandom_range(0, 31));
    // byte stride aliases every 8 bytes across the window
    return word_stride ? {3'b000, sel, 2'b00} : {upper_bits, sel};
  endfunction

  function automatic req_t make_access(logic act, logic [7:0] off, logic [31:0] wd);
    req_t acc;
    acc.action     = act;
    acc.offset     = off;
    acc.write_data = wd;
    acc.rx_avail   = 1'($urandom_range(0, 1));
    acc.rx_data    = 8'($urandom_range(0, 255));
    return acc;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_access(input req_t acc, input bit typed, input logic [7:0] typed_rd);
    rsp_t res;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
    end
    burst_left--;
    req_if.valid   <= 1'b1;
    req_if.payload <= acc;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    res = uart_regs_predict(acc);
    if (typed) res.read_data = typed_rd;
    access_results_q.push_back(res);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_reg(input logic act, input logic [2:0] sel, input logic [31:0] wd);
    send_access(make_access(act, reg_offset(sel), wd), 1'b0, 8'h00);
  endtask

  task automatic run_traffic();
    int next_hold_at;
    int next_drain_at;
    int n;
    logic [31:0] wd;
    logic [2:0] sel;
    next_hold_at  = 300;
    next_drain_at = 550;
    while (beats_sent < TargetBeats) begin
      if (beats_sent >= next_hold_at) begin
        // keep offering while the response side is held off
        hold_off_req = 1'b1;
        burst_left = 3 * HoldOffCycles;
        next_hold_at += 450;
      end
      if (beats_sent >= next_drain_at) begin
        req_if.valid <= 1'b0;
        do @(negedge clk_i); while (access_results_q.size() != 0);
        burst_left = 0;
        drains++;
        next_drain_at += 500;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          // program the baud divisor, read it back, then close the latch
          wd = $urandom();
          send_reg(AccWrite, RegLcr, {wd[31:8], 1'b1, wd[6:0]});
          send_reg(AccWrite, RegRbr, $urandom());
          send_reg(AccWrite, RegIer, $urandom());
          send_reg(AccRead, RegRbr, $urandom());
          send_reg(AccRead, RegIer, $urandom());
          wd = $urandom();
          send_reg(AccWrite, RegLcr, {wd[31:8], 1'b0, wd[6:0]});
        end
        2, 3, 4: begin
          // poll line status, then drain the receive buffer
          n = $urandom_range(1, 4);
          repeat (n) send_reg(AccRead, RegLsr, $urandom());
          n = $urandom_range(0, 2);
          repeat (n) send_reg(AccRead, RegRbr, $urandom());
        end
        5, 6: begin
          n = $urandom_range(1, 6);
          repeat (n) send_reg(AccWrite, RegRbr, $urandom());
        end
        7, 8: begin
          case ($urandom_range(0, 3))
            0: sel = RegIer;
            1: sel = RegLcr;
            2: sel = RegMcr;
            default: sel = RegScr;
          endcase
          wd = $urandom();
          if (sel == RegLcr && $urandom_range(0, 3) != 0) wd[LcrDlabBit] = 1'b0;
          send_reg(AccWrite, sel, wd);
          send_reg(AccRead, sel, $urandom());
        end
        default: begin
          send_access(make_access(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                  $urandom()),
                      1'b0, 8'h00);
        end
      endcase
    end
  endtask

  // ------------------------------------------------------------------
  // Clock, watchdog
  // ------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t ns: no beat for %0d cycles, %0d results still pending",
             $time, WatchdogLimit, access_results_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // ------------------------------------------------------------------
  // Response side: stall pattern and checking
  // ------------------------------------------------------------------
  initial begin
    int mode;
    int pat_left;
    int phase;
    logic [7:0] stall_pat;
    mode = 0;
    pat_left = 0;
    phase = 0;
    stall_pat = '1;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_offs++;
        rsp_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end
      if (pat_left == 0) begin
        mode = $urandom_range(0, 3);
        stall_pat = 8'($urandom_range(1, 255));
        pat_left = $urandom_range(32, 200);
      end
      pat_left--;
      phase++;
      case (mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= 1'($urandom_range(0, 1));
        2: rsp_if.ready <= stall_pat[phase % 8];
        default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic void check_field(string what, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= MaxReportLines) begin
        $display("%0t ns: %s mismatch on result %0d: expected %h, got %h",
                 $time, what, results_seen, exp_v, act_v);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.payload;
      if (access_results_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: result beat with nothing pending: expected none, got %h",
                 $time, got);
      end else begin
        want = access_results_q.pop_front();
        check_field("read_data", want.read_data, got.read_data);
        check_field("tx_valid", {7'b0, want.tx_valid}, {7'b0, got.tx_valid});
        check_field("tx_data", want.tx_data, got.tx_data);
        check_field("irq_level", {7'b0, want.irq_level}, {7'b0, got.irq_level});
        check_field("rx_taken", {7'b0, want.rx_taken}, {7'b0, got.rx_taken});
        if (want.tx_valid) tx_bytes++;
        if (want.rx_taken) rx_latched++;
      end
      results_seen++;
    end
  end

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    dir_row_t row;
    req_t acc;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    word_stride = 1'($urandom_range(0, 1));
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first row reads IIR, which locks the chosen stride
    foreach (DirTable[i]) begin
      row = DirTable[i];
      acc.action     = row.act;
      acc.offset     = row.raw ? row.off : reg_offset(row.sel);
      acc.write_data = row.wd;
      acc.rx_avail   = row.av;
      acc.rx_data    = row.rxd;
      send_access(acc, row.typed, row.rd);
    end

    run_traffic();

    req_if.valid <= 1'b0;
    while (access_results_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    $display("Covered %0d accesses with %s stride, %0d results checked, %0d mismatches.",
             beats_sent, word_stride ? "word" : "byte", results_seen, mismatches);
    $display("Bytes sent: %0d, bytes received: %0d, long hold-offs: %0d, drains: %0d.",
             tx_bytes, rx_latched, hold_offs, drains);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
